FILE: hw/rtl/olst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the ordered list store.
// No dependencies; used by olst_cell and ordered_list_store_core.
package olst_pkg;

    localparam int CAPACITY   = 1024;
    localparam int POS_W      = 11;
    localparam int DATA_W     = 32;
    localparam int GROUP_SIZE = 32;
    localparam int NGROUP     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 48;

    typedef enum logic [2:0] {
        CMD_READ   = 3'd0,
        CMD_HEAD   = 3'd1,
        CMD_TAIL   = 3'd2,
        CMD_AT     = 3'd3,
        CMD_DELETE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_RANGE = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/ordered_list_store_core.sv
`timescale 1ns / 1ps
// Top level of the ordered list store: cell chain, read reduction and handshakes.
// Depends on olst_pkg and olst_cell.
//
// Usage:
//   s_* carries one command per beat (read, add at head, add at tail, add at
//   index, delete) with a position and a value; m_* returns one result beat per
//   command: the value read (-1 unless a read hit), a status code and the list
//   length after the command.
//   Inserts and deletes shift the chain entries from their position on in the cycle the
//   command is accepted. A read selects its cell in that same cycle, ORs each
//   group of 32 cells into a register, then ORs the group registers into the
//   output register in the next cycle.
//   The result beat is valid once the command has passed ST_REDUCE into ST_OUT.
//   One command is handled at a time, through the two-step read reduction and
//   the output register.
//   s_tready is low while a command is in flight or its result waits.
//   Reset empties the list at once; no clearing pass is needed.
//   A stalled receiver holds the result beat and blocks new commands.
module ordered_list_store_core
    import olst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // cmd[2:0], position[13:3], new_value[45:14], zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // read_value[31:0], status[33:32], list_length[44:34], zero pad
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_REDUCE = 3'b010,
        ST_OUT    = 3'b100
    } state_t;

    localparam logic [POS_W-1:0] CAP_COUNT = POS_W'(CAPACITY);

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  count_reg, count_next;
    logic              hit_reg, hit_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] group_reg [NGROUP];
    logic [DATA_W-1:0] group_next [NGROUP];
    logic [DATA_W-1:0] rd_value_reg;
    status_t           rd_status_reg;
    logic [POS_W-1:0]  rd_length_reg;
    logic [DATA_W-1:0] final_or;

    logic              s_accept;
    logic [2:0]        in_cmd;
    logic [POS_W-1:0]  in_pos;
    logic [DATA_W-1:0] in_value;
    logic              full;
    logic              is_insert;
    logic              is_delete;
    logic [POS_W-1:0]  ins_pos;
    cell_ctrl_t        ctrl;

    logic [DATA_W-1:0] cell_value [CAPACITY];
    logic [DATA_W-1:0] cell_read  [CAPACITY];

    assign in_cmd   = s_tdata[2:0];
    assign in_pos   = s_tdata[13:3];
    assign in_value = s_tdata[45:14];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign full     = (count_reg == CAP_COUNT);

    always_comb
    begin
        status_next = STS_RANGE;
        is_insert   = 1'b0;
        is_delete   = 1'b0;
        ins_pos     = in_pos;
        unique case (in_cmd)
            CMD_READ:
            begin
                status_next = (in_pos < count_reg) ? STS_DONE : STS_RANGE;
            end
            CMD_HEAD:
            begin
                is_insert   = 1'b1;
                ins_pos     = '0;
                status_next = full ? STS_FULL : STS_DONE;
            end
            CMD_TAIL:
            begin
                is_insert   = 1'b1;
                ins_pos     = count_reg;
                status_next = full ? STS_FULL : STS_DONE;
            end
            CMD_AT:
            begin
                is_insert = 1'b1;
                if (in_pos > count_reg)
                begin
                    status_next = STS_RANGE;
                end
                else
                begin
                    status_next = full ? STS_FULL : STS_DONE;
                end
            end
            CMD_DELETE:
            begin
                is_delete   = 1'b1;
                status_next = (in_pos < count_reg) ? STS_DONE : STS_RANGE;
            end
            default:
            begin
                status_next = STS_RANGE;
            end
        endcase
    end

    assign hit_next = (in_cmd == CMD_READ) && (status_next == STS_DONE);

    always_comb
    begin
        ctrl.ins   = s_accept && is_insert && (status_next == STS_DONE);
        ctrl.del   = s_accept && is_delete && (status_next == STS_DONE);
        ctrl.pos   = ctrl.ins ? ins_pos : in_pos;
        ctrl.value = in_value;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + POS_W'(1);
        end
        else if (ctrl.del)
        begin
            count_next = count_reg - POS_W'(1);
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        olst_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .index       (POS_W'(i)),
            .left_value  ((i == 0) ? in_value : cell_value[(i == 0) ? 0 : i - 1]),
            .right_value (cell_value[(i == CAPACITY - 1) ? i : i + 1]),
            .value       (cell_value[i]),
            .read_data   (cell_read[i])
        );
    end

    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < CAPACITY)
                begin
                    group_next[g] = group_next[g] | cell_read[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_comb
    begin
        final_or = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            final_or = final_or | group_reg[g];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            hit_reg    <= hit_next;
            status_reg <= status_next;
            for (int g = 0; g < NGROUP; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
        if (state_reg == ST_REDUCE)
        begin
            rd_value_reg  <= hit_reg ? final_or : '1;
            rd_status_reg <= status_reg;
            rd_length_reg <= count_reg;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {(OUT_W - DATA_W - 2 - POS_W)'(0), rd_length_reg, rd_status_reg,
                       rd_value_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("list length exceeds capacity");

    a_accept_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> state_reg == ST_REDUCE)
        else $error("accepted beat did not start the reduction");

    a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (count_reg == $past(count_reg)
                      || count_reg == $past(count_reg) + POS_W'(1)
                      || count_reg == $past(count_reg) - POS_W'(1)))
        else $error("list length moved by more than one");

    a_len_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_accept |=> $stable(count_reg))
        else $error("list length changed without a command");

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

endmodule

FILE: hw/rtl/olst_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one entry, shifts with its neighbors.
// Depends on olst_pkg.
module olst_cell
    import olst_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [POS_W-1:0]  index,
    input  logic [DATA_W-1:0] left_value,
    input  logic [DATA_W-1:0] right_value,
    output logic [DATA_W-1:0] value,
    output logic [DATA_W-1:0] read_data
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (index > ctrl.pos)
            begin
                value_next = left_value;
            end
            else if (index == ctrl.pos)
            begin
                value_next = ctrl.value;
            end
        end
        else if (ctrl.del && (index >= ctrl.pos))
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    assign read_data = value_reg & {DATA_W{index == ctrl.pos}};

endmodule
